>>> rtl/tsdx_pkg.sv
// Shared types and constants for the time-series delta/XOR frame encoder.
// Depends on nothing; the top level timeseries_delta_xor_encoder imports it.
package tsdx_pkg;

    localparam int IDX_W      = 4;
    localparam int TS_BYTES   = 10;
    localparam int TAIL_BYTES = 9;
    localparam int LEN_W      = 21;
    localparam int ADDR_W     = 3;

    localparam logic [LEN_W-1:0] CAP_RESET        = 21'h100000;
    localparam logic             REG_OUT_CAPACITY = 1'b0;

    typedef struct packed {
        logic signed [63:0] timestamp;
        logic        [63:0] value_bits;
        logic               first;
        logic        [19:0] sample_count;
    } sample_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             last_of_sample;
        logic             frame_end;
        logic             overflow;
        logic [LEN_W-1:0] frame_length;
    } result_t;

endpackage

>>> rtl/tsdx_stream_if.sv
// Valid/ready stream channel used for the sample input and the byte output.
// The payload type is a parameter; the encoder uses the structs of tsdx_pkg.
interface tsdx_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/timeseries_delta_xor_encoder.sv
// Top level of the time-series delta/XOR frame encoder.
// Depends on tsdx_pkg and the tsdx_stream_if channel interface.
//
// Samples arrive as beats on the sample channel; each accepted sample becomes
// a sequence of byte beats on the coded channel, one byte per cycle while the
// receiver is ready. The first sample of a frame gives the varint sample
// count, the varint timestamp and eight value bytes (up to 21 bytes); a later
// sample gives the varint zigzag timestamp delta and the XOR-coded value (up
// to 19 bytes). A frame that would exceed out_capacity gives one overflow
// beat instead, and its later samples are dropped; a sample outside any open
// frame gives no beat. A sample is held in an input register, converted
// combinationally and loaded into a byte buffer, and the buffer feeds an
// output register over the single byte lane, one byte per cycle while the
// receiver is ready; the next sample is taken while the current one drains.
// When the receiver stalls, the output register holds its beat and the input
// stops once both buffers are full.
// Reset empties all stages, closes any frame and sets out_capacity to 2^20.
// out_capacity is written through the APB port at address 0.
module timeseries_delta_xor_encoder #(
    parameter int COUNT_BITS = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsdx_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    tsdx_stream_if.sink                sample,
    tsdx_stream_if.source              coded
);
    import tsdx_pkg::*;

    localparam int CNT_BYTES = (COUNT_BITS + 6) / 7;
    localparam int CNT_PAD   = CNT_BYTES * 7;
    localparam int CL_W      = $clog2(CNT_BYTES + 1);
    localparam int CI_W      = $clog2(CNT_BYTES);

    typedef enum logic [1:0] {PH_CNT, PH_TS, PH_TAIL, PH_OVF} phase_t;

    logic [LEN_W-1:0]      cap_reg;
    logic                  it_vld_reg;
    sample_t               it_reg;
    logic [63:0]           prev_time_reg;
    logic [63:0]           prev_value_reg;
    logic [COUNT_BITS-1:0] samples_left_reg;
    logic [LEN_W-1:0]      bytes_used_reg;

    logic                  buf_vld_reg;
    phase_t                phase_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [COUNT_BITS-1:0] cnt_v_reg;
    logic [CL_W-1:0]       cnt_len_reg;
    logic [63:0]           ts_v_reg;
    logic [IDX_W-1:0]      ts_len_reg;
    logic [8*TAIL_BYTES-1:0] tail_reg;
    logic [IDX_W-1:0]      tail_len_reg;
    logic                  end_reg;
    logic [LEN_W-1:0]      flen_reg;

    logic                  out_vld_reg;
    result_t               out_reg;

    logic                  cfg_wr;
    logic [63:0]           delta;
    logic [63:0]           zz;
    logic [63:0]           ts_v;
    logic [IDX_W-1:0]      ts_len;
    logic [COUNT_BITS-1:0] cnt;
    logic [CL_W-1:0]       cnt_len;
    logic [CL_W-1:0]       cnt_len_eff;
    logic [63:0]           xv;
    logic [IDX_W-1:0]      lead;
    logic [IDX_W-1:0]      trail;
    logic [IDX_W-1:0]      sig;
    logic [63:0]           mant;
    logic [8*TAIL_BYTES-1:0] tail;
    logic [IDX_W-1:0]      tail_len;
    logic [4:0]            total;
    logic [LEN_W-1:0]      base;
    logic [LEN_W:0]        need;
    logic                  over;
    logic                  drop;
    logic [COUNT_BITS-1:0] new_left;

    logic [6:0]            cnt_grp [CNT_BYTES];
    logic [6:0]            ts_grp  [TS_BYTES];
    logic                  seg_last;
    logic                  item_last;
    logic [7:0]            cur_byte;
    result_t               cur_res;
    logic                  out_free;
    logic                  emit;
    logic                  buf_done;
    logic                  proc;
    logic                  load;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_OUT_CAPACITY);
    assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? {11'd0, cap_reg} : 32'd0;

    always_comb
    begin
        delta = it_reg.timestamp - prev_time_reg;
        zz    = {delta[62:0], 1'b0} ^ {64{delta[63]}};
        ts_v  = it_reg.first ? it_reg.timestamp : zz;
        ts_len = IDX_W'(1);
        for (int g = 1; g < TS_BYTES; g++)
        begin
            if ((ts_v >> (7 * g)) != 64'd0)
            begin
                ts_len = IDX_W'(g + 1);
            end
        end

        cnt     = COUNT_BITS'(it_reg.sample_count);
        cnt_len = CL_W'(1);
        for (int g = 1; g < CNT_BYTES; g++)
        begin
            if ((CNT_PAD'(cnt) >> (7 * g)) != '0)
            begin
                cnt_len = CL_W'(g + 1);
            end
        end
        cnt_len_eff = it_reg.first ? cnt_len : '0;

        xv   = it_reg.value_bits ^ prev_value_reg;
        lead = IDX_W'(8);
        for (int k = 0; k < 8; k++)
        begin
            if (xv[8*k +: 8] != 8'd0)
            begin
                lead = IDX_W'(7 - k);
            end
        end
        trail = IDX_W'(8);
        for (int k = 7; k >= 0; k--)
        begin
            if (xv[8*k +: 8] != 8'd0)
            begin
                trail = IDX_W'(k);
            end
        end
        sig  = IDX_W'(8) - lead - trail;
        mant = xv >> (8 * trail);

        if (it_reg.first)
        begin
            tail     = {8'h00, it_reg.value_bits};
            tail_len = IDX_W'(8);
        end
        else if (xv == 64'd0)
        begin
            tail     = '0;
            tail_len = IDX_W'(1);
        end
        else
        begin
            tail     = {mant, lead, sig - IDX_W'(1)};
            tail_len = sig + IDX_W'(1);
        end

        total = 5'(cnt_len_eff) + 5'(ts_len) + 5'(tail_len);
        base  = it_reg.first ? '0 : bytes_used_reg;
        need  = {1'b0, base} + (LEN_W + 1)'(total);
        over  = need > {1'b0, cap_reg};
        drop  = !it_reg.first && (samples_left_reg == '0);
        if (it_reg.first)
        begin
            new_left = (cnt != '0) ? cnt - COUNT_BITS'(1) : '0;
        end
        else
        begin
            new_left = samples_left_reg - COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        for (int g = 0; g < CNT_BYTES; g++)
        begin
            cnt_grp[g] = 7'(CNT_PAD'(cnt_v_reg) >> (7 * g));
        end
        for (int g = 0; g < TS_BYTES; g++)
        begin
            ts_grp[g] = 7'(ts_v_reg >> (7 * g));
        end

        case (phase_reg)
            PH_CNT:
            begin
                seg_last  = idx_reg == IDX_W'(cnt_len_reg) - IDX_W'(1);
                item_last = 1'b0;
                cur_byte  = {!seg_last, cnt_grp[idx_reg[CI_W-1:0]]};
            end
            PH_TS:
            begin
                seg_last  = idx_reg == ts_len_reg - IDX_W'(1);
                item_last = 1'b0;
                cur_byte  = {!seg_last, ts_grp[idx_reg]};
            end
            PH_TAIL:
            begin
                seg_last  = idx_reg == tail_len_reg - IDX_W'(1);
                item_last = seg_last;
                cur_byte  = tail_reg[8*idx_reg +: 8];
            end
            default:
            begin
                seg_last  = 1'b1;
                item_last = 1'b1;
                cur_byte  = 8'h00;
            end
        endcase

        cur_res.out_byte       = cur_byte;
        cur_res.last_of_sample = item_last;
        cur_res.overflow       = phase_reg == PH_OVF;
        cur_res.frame_end      = item_last && (end_reg || phase_reg == PH_OVF);
        cur_res.frame_length   = (phase_reg == PH_OVF) ? flen_reg
                                                       : flen_reg + LEN_W'(1);
    end

    assign out_free     = !out_vld_reg || coded.ready;
    assign emit         = buf_vld_reg && out_free;
    assign buf_done     = emit && item_last;
    assign proc         = it_vld_reg && (!buf_vld_reg || buf_done || drop);
    assign load         = proc && !drop;
    assign sample.ready = !it_vld_reg || proc;
    assign coded.valid  = out_vld_reg;
    assign coded.data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr)
        begin
            cap_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            it_vld_reg       <= 1'b0;
            prev_time_reg    <= '0;
            prev_value_reg   <= '0;
            samples_left_reg <= '0;
            bytes_used_reg   <= '0;
            buf_vld_reg      <= 1'b0;
            phase_reg        <= PH_TS;
            idx_reg          <= '0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                it_vld_reg <= 1'b1;
            end
            else if (proc)
            begin
                it_vld_reg <= 1'b0;
            end

            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (coded.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (load)
            begin
                buf_vld_reg <= 1'b1;
                idx_reg     <= '0;
                if (over)
                begin
                    phase_reg        <= PH_OVF;
                    samples_left_reg <= '0;
                    bytes_used_reg   <= base;
                end
                else
                begin
                    phase_reg        <= it_reg.first ? PH_CNT : PH_TS;
                    samples_left_reg <= new_left;
                    bytes_used_reg   <= need[LEN_W-1:0];
                    prev_time_reg    <= it_reg.timestamp;
                    prev_value_reg   <= it_reg.value_bits;
                end
            end
            else if (emit)
            begin
                if (seg_last)
                begin
                    idx_reg <= '0;
                    if (phase_reg == PH_CNT)
                    begin
                        phase_reg <= PH_TS;
                    end
                    else if (phase_reg == PH_TS)
                    begin
                        phase_reg <= PH_TAIL;
                    end
                    else
                    begin
                        buf_vld_reg <= 1'b0;
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            it_reg <= sample.data;
        end
        if (emit)
        begin
            out_reg <= cur_res;
        end
        if (load)
        begin
            cnt_v_reg    <= cnt;
            cnt_len_reg  <= cnt_len;
            ts_v_reg     <= ts_v;
            ts_len_reg   <= ts_len;
            tail_reg     <= tail;
            tail_len_reg <= tail_len;
            end_reg      <= new_left == '0;
            flen_reg     <= base;
        end
        else if (emit && phase_reg != PH_OVF)
        begin
            flen_reg <= flen_reg + LEN_W'(1);
        end
    end

    a_ovf_closes: assert property (@(posedge clk) disable iff (!rst_n)
        coded.valid && coded.data.overflow
        |-> coded.data.last_of_sample && coded.data.frame_end)
        else $error("Overflow beat does not close the sample and the frame.");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        coded.valid && coded.data.frame_end |-> coded.data.last_of_sample)
        else $error("Frame end on a byte that does not close its sample.");

    a_sample_continues: assert property (@(posedge clk) disable iff (!rst_n)
        coded.valid && coded.ready && !coded.data.last_of_sample
        |=> out_vld_reg || buf_vld_reg)
        else $error("Sample bytes lost after a non-final beat.");

    a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !buf_vld_reg || buf_done)
        else $error("Byte buffer reloaded before it drained.");

endmodule
